// ===== hw/rtl/dda_line_rasterizer_unit_assert.svh =====
// Assertion macros for the DDA line rasterizer
`ifndef DDA_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define DDA_LINE_RASTERIZER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define DDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define DDA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DDA_ASSERT(label, prop, msg)
`define DDA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hw/rtl/dda_lr_pkg.sv =====
// Shared constants and types for the DDA line rasterizer
package dda_lr_pkg;

  localparam int DEF_MAX_STEPS = 63;
  localparam int DEF_FRAC_BITS = 16;

  localparam int COORD_W   = 12;  // input coordinates and offsets
  localparam int POINT_W   = 13;  // translated coordinates and emitted points
  localparam int MAG_W     = 12;  // |dx|, |dy| and step count
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/dda_lr_div.sv =====
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den, num <= den
module dda_lr_div #(
  parameter int FRAC_BITS = dda_lr_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [dda_lr_pkg::MAG_W-1:0]      num,
  input  logic [dda_lr_pkg::MAG_W-1:0]      den,
  output logic [FRAC_BITS:0]                quot,
  output dda_lr_pkg::div_stat_t             stat
);

  localparam int QW    = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(FRAC_BITS + 2);
  localparam int RW    = dda_lr_pkg::MAG_W + 1;

  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [RW-1:0]    rem;
  logic [RW-1:0]    den_r;
  logic [RW:0]      diff;
  logic             ge;
  logic [RW-2:0]    rem_sel;

  // remainder stays below the divisor, so the shifted value fits RW bits
  assign diff    = {1'b0, rem} - {2'b00, den_r[RW-2:0]};
  assign ge      = ~diff[RW];
  assign rem_sel = ge ? diff[RW-2:0] : rem[RW-2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(QW);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      den_r <= {1'b0, den};
      quot  <= '0;
    end else if (cnt != '0) begin
      rem  <= {rem_sel, 1'b0};
      quot <= {quot[QW-2:0], ge};
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

// ===== hw/rtl/dda_line_rasterizer_unit.sv =====
// DDA line rasterizer top level: sequencer, accumulators and output register
//
// Takes one segment (two 12-bit endpoints), adds the configured offsets and walks
// from start to end in max(|dx|,|dy|) steps, emitting the start point and one
// rounded point per step, the final one marked with last_point. Segments longer
// than MAX_STEPS are cut after MAX_STEPS steps and every point is flagged
// truncated; a zero-length segment gives its start point only. Per segment the
// block latches the item, then computes the two increments, which share one
// restoring divider producing one quotient bit per cycle (a start step, the
// quotient bit steps and a done step per increment) and are skipped for
// zero-length segments, then emits one point per cycle while the output is not
// stalled, up to MAX_STEPS+1 points. in_stall stays high from acceptance until
// the last point is loaded into the output register. Offsets are written through
// the cfg port (index 0: x, index 1: y; other indices are ignored); the user must
// write them only while the block is idle, which the block itself does not enforce.
`include "dda_line_rasterizer_unit_assert.svh"

module dda_line_rasterizer_unit #(
  parameter int MAX_STEPS = dda_lr_pkg::DEF_MAX_STEPS,
  parameter int FRAC_BITS = dda_lr_pkg::DEF_FRAC_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [dda_lr_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [dda_lr_pkg::COORD_W-1:0]          cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [dda_lr_pkg::COORD_W-1:0]   start_x,
  input  logic signed [dda_lr_pkg::COORD_W-1:0]   start_y,
  input  logic signed [dda_lr_pkg::COORD_W-1:0]   end_x,
  input  logic signed [dda_lr_pkg::COORD_W-1:0]   end_y,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [dda_lr_pkg::POINT_W-1:0]   point_x,
  output logic signed [dda_lr_pkg::POINT_W-1:0]   point_y,
  output logic                                    last_point,
  output logic                                    truncated
);

  localparam int CW    = dda_lr_pkg::COORD_W;
  localparam int PW    = dda_lr_pkg::POINT_W;
  localparam int MW    = dda_lr_pkg::MAG_W;
  localparam int SC_W  = $clog2(MAX_STEPS + 1);
  localparam int ACC_W = FRAC_BITS + PW + 1;
  localparam int INC_W = FRAC_BITS + 2;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV_X = 2'd1;
  localparam logic [1:0] S_DIV_Y = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  logic [1:0]             state;
  logic [CW-1:0]          offset_x;
  logic [CW-1:0]          offset_y;
  logic [ACC_W-1:0]       acc_x;
  logic [ACC_W-1:0]       acc_y;
  logic [INC_W-1:0]       inc_x;
  logic [INC_W-1:0]       inc_y;
  logic [SC_W-1:0]        step_cnt;
  logic [SC_W-1:0]        taken;
  logic                   cut;
  logic [MW-1:0]          mag_x;
  logic [MW-1:0]          mag_y;
  logic [MW-1:0]          steps;
  logic                   neg_x;
  logic                   neg_y;
  logic                   div_start;

  logic                   in_take;
  logic                   out_load;
  logic [PW-1:0]          sx;
  logic [PW-1:0]          sy;
  logic [PW-1:0]          dx;
  logic [PW-1:0]          dy;
  logic [PW-1:0]          abs_dx;
  logic [PW-1:0]          abs_dy;
  logic [MW-1:0]          steps_in;
  logic                   cut_in;
  logic [FRAC_BITS:0]     quot;
  logic [INC_W-1:0]       quot_ext;
  logic                   quot_neg;
  logic [INC_W-1:0]       inc_signed;
  logic [ACC_W-1:0]       sum_x;
  logic [ACC_W-1:0]       sum_y;
  dda_lr_pkg::div_stat_t  div_stat;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_load  = (state == S_EMIT) && (!out_valid || !out_stall);

  // translated start; the offsets cancel in the differences
  assign sx = {start_x[CW-1], start_x} + {offset_x[CW-1], offset_x};
  assign sy = {start_y[CW-1], start_y} + {offset_y[CW-1], offset_y};
  assign dx = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
  assign dy = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
  assign abs_dx   = dx[PW-1] ? (~dx + 1'b1) : dx;
  assign abs_dy   = dy[PW-1] ? (~dy + 1'b1) : dy;
  assign steps_in = (abs_dx[MW-1:0] > abs_dy[MW-1:0]) ? abs_dx[MW-1:0] : abs_dy[MW-1:0];
  assign cut_in   = steps_in > MW'(MAX_STEPS);

  assign quot_ext   = {1'b0, quot};
  assign quot_neg   = (state == S_DIV_X) ? neg_x : neg_y;
  assign inc_signed = quot_neg ? (~quot_ext + 1'b1) : quot_ext;

  // floor(v + 0.5): add a half, then take the integer bits
  assign sum_x = acc_x + HALF;
  assign sum_y = acc_y + HALF;

  dda_lr_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ((state == S_DIV_X) ? mag_x : mag_y),
    .den   (steps),
    .quot  (quot),
    .stat  (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dda_lr_pkg::REG_OFFSET_X: offset_x <= cfg_data;
        dda_lr_pkg::REG_OFFSET_Y: offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      out_valid <= 1'b0;
      step_cnt  <= '0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            step_cnt <= '0;
            if (steps_in == '0) begin
              state <= S_EMIT;
            end else begin
              state     <= S_DIV_X;
              div_start <= 1'b1;
            end
          end
        end
        S_DIV_X: begin
          if (div_stat.done) begin
            state     <= S_DIV_Y;
            div_start <= 1'b1;
          end
        end
        S_DIV_Y: begin
          if (div_stat.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            if (step_cnt == taken) begin
              state <= S_IDLE;
            end else begin
              step_cnt <= step_cnt + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      acc_x <= {{(ACC_W - FRAC_BITS - PW){sx[PW-1]}}, sx, {FRAC_BITS{1'b0}}};
      acc_y <= {{(ACC_W - FRAC_BITS - PW){sy[PW-1]}}, sy, {FRAC_BITS{1'b0}}};
      inc_x <= '0;
      inc_y <= '0;
      mag_x <= abs_dx[MW-1:0];
      mag_y <= abs_dy[MW-1:0];
      neg_x <= dx[PW-1];
      neg_y <= dy[PW-1];
      steps <= steps_in;
      cut   <= cut_in;
      taken <= cut_in ? SC_W'(MAX_STEPS) : steps_in[SC_W-1:0];
    end else if (state == S_DIV_X && div_stat.done) begin
      inc_x <= inc_signed;
    end else if (state == S_DIV_Y && div_stat.done) begin
      inc_y <= inc_signed;
    end else if (out_load) begin
      acc_x <= acc_x + {{(ACC_W - INC_W){inc_x[INC_W-1]}}, inc_x};
      acc_y <= acc_y + {{(ACC_W - INC_W){inc_y[INC_W-1]}}, inc_y};
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      point_x    <= sum_x[FRAC_BITS +: PW];
      point_y    <= sum_y[FRAC_BITS +: PW];
      last_point <= (step_cnt == taken);
      truncated  <= cut;
    end
  end

  `DDA_ASSERT_ALWAYS(a_rst_idle, rst |=> (state == S_IDLE) && !out_valid, "reset left block busy")
  `DDA_ASSERT(a_emit_src, $rose(out_valid) |-> $past(state) == S_EMIT, "point loaded outside emit")
  `DDA_ASSERT(a_step_bound, (state == S_EMIT) |-> (step_cnt <= taken), "step count overran")
  `DDA_ASSERT(a_div_owner, div_stat.done |-> (state == S_DIV_X || state == S_DIV_Y), "stray divide")
  `DDA_ASSERT(a_idle_div, (state == S_IDLE) |-> !div_stat.busy, "divider busy while idle")

endmodule

// ===== tb/dda_line_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the DDA line rasterizer: tracks offsets, predicts every point and compares
module dda_line_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [dda_lr_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [dda_lr_pkg::COORD_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [dda_lr_pkg::COORD_W-1:0] start_x,
  input  logic signed [dda_lr_pkg::COORD_W-1:0] start_y,
  input  logic signed [dda_lr_pkg::COORD_W-1:0] end_x,
  input  logic signed [dda_lr_pkg::COORD_W-1:0] end_y,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [dda_lr_pkg::POINT_W-1:0] point_x,
  input  logic signed [dda_lr_pkg::POINT_W-1:0] point_y,
  input  logic                                  last_point,
  input  logic                                  truncated,
  output int                                    fail_cnt,
  output int                                    open_cnt,
  output int                                    seg_cnt,
  output int                                    pix_cnt,
  output int                                    cut_cnt
);
  import dda_lr_pkg::*;

  localparam longint ONE = longint'(1) << DEF_FRAC_BITS;
  localparam longint HALF = ONE / 2;
  localparam int REPORT_CAP = 40;

  typedef struct packed {
    logic signed [POINT_W-1:0] px;
    logic signed [POINT_W-1:0] py;
    logic                      last;
    logic                      cut;
  } pixel_t;

  logic signed [COORD_W-1:0] ofs_x = '0;
  logic signed [COORD_W-1:0] ofs_y = '0;
  pixel_t pixel_q[$];

  // floor(acc + 0.5); arithmetic shift of a signed value is a floor
  function automatic logic signed [POINT_W-1:0] snap(longint acc);
    longint r;
    r = (acc + HALF) >>> DEF_FRAC_BITS;
    return r[POINT_W-1:0];
  endfunction

  // Queues every point of one segment; returns 1 when the segment is cut
  function automatic bit plot_segment(input logic signed [COORD_W-1:0] sx, sy, ex, ey);
    longint ax, ay, dx, dy, mx, my, span, walk, step_x, step_y, acc_x, acc_y;
    bit     cut;
    pixel_t p;
    ax = longint'(sx) + longint'(ofs_x);
    ay = longint'(sy) + longint'(ofs_y);
    dx = longint'(ex) + longint'(ofs_x) - ax;
    dy = longint'(ey) + longint'(ofs_y) - ay;
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    span = (mx > my) ? mx : my;
    cut = span > DEF_MAX_STEPS;
    walk = cut ? DEF_MAX_STEPS : span;
    acc_x = ax * ONE;
    acc_y = ay * ONE;
    if (span == 0) begin
      step_x = 0;
      step_y = 0;
    end else begin
      // SV division truncates toward zero, as the increments require
      step_x = (dx * ONE) / span;
      step_y = (dy * ONE) / span;
    end
    p.px = snap(acc_x);
    p.py = snap(acc_y);
    p.last = (span == 0);
    p.cut = cut;
    pixel_q.push_back(p);
    for (longint k = 1; k <= walk; k++) begin
      acc_x += step_x;
      acc_y += step_y;
      p.px = snap(acc_x);
      p.py = snap(acc_y);
      p.last = (k == walk);
      p.cut = cut;
      pixel_q.push_back(p);
    end
    return cut;
  endfunction

  function automatic int field_bad(string name, logic signed [POINT_W-1:0] want, got);
    if (got === want) return 0;
    if (fail_cnt < REPORT_CAP) $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    int     errs;
    errs = 0;
    if (rst) begin
      ofs_x = '0;
      ofs_y = '0;
      pixel_q.delete();
      fail_cnt <= 0;
      open_cnt <= 0;
      seg_cnt <= 0;
      pix_cnt <= 0;
      cut_cnt <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_OFFSET_X) ofs_x = cfg_data;
        else if (cfg_index == REG_OFFSET_Y) ofs_y = cfg_data;
      end
      // retire before queuing: a point leaving now never belongs to a request taken now
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          errs++;
          if (fail_cnt < REPORT_CAP)
            $error("point (%0d, %0d) arrived with nothing expected", point_x, point_y);
        end else begin
          want = pixel_q.pop_front();
          errs += field_bad("point_x", want.px, point_x);
          errs += field_bad("point_y", want.py, point_y);
          errs += field_bad("last_point", POINT_W'(want.last), POINT_W'(last_point));
          errs += field_bad("truncated", POINT_W'(want.cut), POINT_W'(truncated));
        end
        pix_cnt <= pix_cnt + 1;
      end
      if (in_valid && !in_stall) begin
        if (plot_segment(start_x, start_y, end_x, end_y)) cut_cnt <= cut_cnt + 1;
        seg_cnt <= seg_cnt + 1;
      end
      fail_cnt <= fail_cnt + errs;
      open_cnt <= pixel_q.size();
    end
  end

endmodule

// ===== tb/tb_dda_line_rasterizer_unit.sv =====
`timescale 1ns / 100ps
// Testbench top for the DDA line rasterizer: stimulus, output idling, watchdog and verdict
module tb_dda_line_rasterizer_unit;
  import dda_lr_pkg::*;

  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 40;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [REG_IDX_W-1:0]      cfg_index = '0;
  logic [COORD_W-1:0]        cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] start_x = '0;
  logic signed [COORD_W-1:0] start_y = '0;
  logic signed [COORD_W-1:0] end_x = '0;
  logic signed [COORD_W-1:0] end_y = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;
  logic                      last_point;
  logic                      truncated;

  int fail_cnt, open_cnt, seg_cnt, pix_cnt, cut_cnt;
  bit steady = 1'b0;       // sender offers back to back
  bit squeeze_req = 1'b0;  // asks the receiver for its one long hold-off

  int ofs_x_tab[4] = '{2047, -2048, 2047, -2048};
  int ofs_y_tab[4] = '{2047, -2048, -2048, 2047};

  dda_line_rasterizer_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .point_x(point_x), .point_y(point_y), .last_point(last_point), .truncated(truncated)
  );

  dda_line_checker scoreboard (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .point_x(point_x), .point_y(point_y), .last_point(last_point), .truncated(truncated),
    .fail_cnt(fail_cnt), .open_cnt(open_cnt), .seg_cnt(seg_cnt), .pix_cnt(pix_cnt),
    .cut_cnt(cut_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // leaves cfg_valid high so back-to-back writes need a single assignment per step
  task automatic cfg_put(input logic [REG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_offsets(input int ox, input int oy, input bit spare_b);
    cfg_put(REG_OFFSET_X, ox[COORD_W-1:0]);
    cfg_put(REG_OFFSET_Y, oy[COORD_W-1:0]);
    // unmapped index, must leave both offsets alone
    cfg_put(spare_b ? REG_SPARE_B : REG_SPARE_A, COORD_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_segment(input logic signed [COORD_W-1:0] sx, sy, ex, ey);
    int gap, pick;
    gap = 0;
    if (!steady) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) gap = $urandom_range(1, 4);
      else if (pick < 45) gap = $urandom_range(10, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid, then wait for every queued point to come back
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_cnt != 0) @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] reach(logic signed [COORD_W-1:0] s, int d);
    int e;
    e = int'(s) + d;
    if (e > 2047 || e < -2048) e = int'(s) - d;
    return e[COORD_W-1:0];
  endfunction

  // mostly short segments, a few of zero length, some near the step limit, a few spanning the whole range
  task automatic gen_segment(output logic signed [COORD_W-1:0] sx, sy, ex, ey);
    int cls, ddx, ddy;
    sx = COORD_W'($urandom);
    sy = COORD_W'($urandom);
    cls = $urandom_range(0, 99);
    if (cls < 5) begin
      ddx = 0;
      ddy = 0;
    end else if (cls < 70) begin
      ddx = int'($urandom_range(0, 24)) - 12;
      ddy = int'($urandom_range(0, 24)) - 12;
    end else begin
      ddx = int'($urandom_range(0, 140)) - 70;
      ddy = int'($urandom_range(0, 140)) - 70;
    end
    if (cls >= 92) begin
      ex = COORD_W'($urandom);
      ey = COORD_W'($urandom);
    end else begin
      ex = reach(sx, ddx);
      ey = reach(sy, ddy);
    end
  endtask

  initial begin : receiver
    int pick, hold;
    bit squeezed;
    squeezed = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          out_stall <= 1'b0;
          hold = $urandom_range(1, 40);
        end else if (pick < 85) begin
          out_stall <= 1'b1;
          hold = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          hold = $urandom_range(10, 60);
        end
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic signed [COORD_W-1:0] sx, sy, ex, ey;
    int ox, oy;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_offsets(0, 0, 1'b0);
    send_segment(-2048, -2048, -2048, -2048);  // zero length, bottom corner
    send_segment(2047, 2047, 2047, 2047);      // zero length, top corner
    send_segment(0, 0, 10, 0);
    send_segment(0, 0, 0, -10);
    send_segment(5, 5, -5, -5);
    send_segment(0, 0, 1, 2);                  // half-way ties
    send_segment(0, 0, -1, -2);                // ties going negative
    send_segment(0, 0, 3, 7);
    send_segment(0, 0, 63, 20);                // right at the step limit
    send_segment(0, 0, -64, 5);                // one past it
    send_segment(-2048, -2048, 2047, 2047);    // longest span
    send_segment(2047, -2048, -2048, 2047);
    send_segment(-2048, 2047, 2047, -2048);
    send_segment(100, -200, -300, -150);
    send_segment(-1, -1, 0, 0);
    send_segment(-2048, 2047, -1985, 2000);
    send_segment(1000, 1000, 1007, 1003);
    finish_phase();

    for (int ph = 0; ph < PHASES; ph++) begin
      steady = (ph == 1 || ph == 4);
      if (ph == 2) squeeze_req = 1'b1;
      if (ph < 4) begin
        ox = ofs_x_tab[ph];
        oy = ofs_y_tab[ph];
      end else begin
        ox = int'($urandom_range(0, 4095)) - 2048;
        oy = int'($urandom_range(0, 4095)) - 2048;
      end
      set_offsets(ox, oy, ph[0]);
      if (ph < 4) begin
        // translated extremes under the corner offsets
        send_segment(2047, 2047, -2048, -2048);
        send_segment(-2048, -2048, -2048, -2048);
      end
      repeat (PHASE_ITEMS) begin
        gen_segment(sx, sy, ex, ey);
        send_segment(sx, sy, ex, ey);
      end
      finish_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d segments (%0d cut at the step limit), %0d points checked,",
             seg_cnt, cut_cnt, pix_cnt);
    $display("over seven offset settings including all four corner extremes.");
    if (fail_cnt == 0 && open_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
